// ----- hdl/box_frustum_cull_test_unit_assert.svh -----
// Assertion macros for the box frustum cull test unit.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef BOX_FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH
`define BOX_FRUSTUM_CULL_TEST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfc assertion failed");

`endif

// ----- hdl/bfc_pkg.sv -----
// Shared types and constants for the box frustum cull test unit.
// Depends on nothing; used by bfc_xform, bfc_cell and the top level.
package bfc_pkg;

    // Opcodes of an input item.
    localparam logic [1:0] OP_PLANE = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    // Width of the exact plane-test sums (products of up to 96 bits plus growth).
    localparam int ACC_W = 104;

    // Control that travels with each item down the chain.
    typedef struct packed {
        logic vld;
        logic is_test;
        logic is_pload;
        logic vis;
    } ctl_t;

    // Payload that travels with each item: plane words for loads, and for tests
    // the matrix translations and the row-coefficient times box-coordinate products,
    // indexed [axis][coordinate][min or max].
    typedef struct packed {
        logic [2:0]                   slot;
        logic [3:0][31:0]             words;
        logic [2:0][31:0]             trans;
        logic [2:0][2:0][1:0][63:0]   prod;
    } item_t;

endpackage

// ----- hdl/bfc_xform.sv -----
// Front stage: holds the three affine rows and forms the per-axis products of a box.
// Depends on bfc_pkg.
module bfc_xform
    import bfc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        fire,
    input  logic [1:0]  opcode,
    input  logic [2:0]  slot,
    input  logic signed [31:0] word_a,
    input  logic signed [31:0] word_b,
    input  logic signed [31:0] word_c,
    input  logic signed [31:0] word_d,
    input  logic signed [31:0] word_e,
    input  logic signed [31:0] word_f,
    output ctl_t        ctl_o,
    output item_t       item_o
);

    logic signed [31:0] row_reg [3][4];
    ctl_t               ctl_reg;
    ctl_t               ctl_next;
    item_t              item_reg;
    item_t              item_next;

    // Matrix rows, identity after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    row_reg[a][j] <= (a == j) ? (32'(1) << FRACTION_BITS) : 32'sd0;
                end
            end
        end
        else if (fire && opcode == OP_ROW && slot < 3'd3)
        begin
            row_reg[slot[1:0]][0] <= word_a;
            row_reg[slot[1:0]][1] <= word_b;
            row_reg[slot[1:0]][2] <= word_c;
            row_reg[slot[1:0]][3] <= word_d;
        end
    end

    // Control for the chain; row loads and unused opcodes end here.
    always_comb
    begin
        ctl_next.vld      = fire && (opcode == OP_PLANE || opcode == OP_TEST);
        ctl_next.is_test  = opcode == OP_TEST;
        ctl_next.is_pload = opcode == OP_PLANE;
        ctl_next.vis      = 1'b1;
    end

    // Products of each row coefficient with the box minimum and maximum.
    always_comb
    begin
        logic signed [31:0] lo [3];
        logic signed [31:0] hi [3];
        logic signed [63:0] p;
        lo[0] = word_a;
        lo[1] = word_b;
        lo[2] = word_c;
        hi[0] = word_d;
        hi[1] = word_e;
        hi[2] = word_f;
        item_next.slot  = slot;
        item_next.words = {word_d, word_c, word_b, word_a};
        for (int a = 0; a < 3; a++)
        begin
            item_next.trans[a] = row_reg[a][3];
            for (int j = 0; j < 3; j++)
            begin
                p = row_reg[a][j] * lo[j];
                item_next.prod[a][j][0] = p;
                p = row_reg[a][j] * hi[j];
                item_next.prod[a][j][1] = p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign ctl_o  = ctl_reg;
    assign item_o = item_reg;

endmodule

// ----- hdl/bfc_cell.sv -----
// One plane of the chain: holds a plane and tests each passing box against it.
// Depends on bfc_pkg.
module bfc_cell
    import bfc_pkg::*;
#(
    parameter int CELL_IDX      = 0,
    parameter int FRACTION_BITS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  ctl_t  ctl_i,
    input  item_t item_i,
    output ctl_t  ctl_o,
    output item_t item_o
);

    logic signed [31:0] nrm_reg [3];
    logic signed [31:0] dist_reg;
    logic               hit;

    ctl_t  ctl_a_reg, ctl_b_reg, ctl_c_reg, ctl_d_reg, ctl_e_reg;
    ctl_t  ctl_e_next;
    item_t item_a_reg, item_b_reg, item_c_reg, item_d_reg, item_e_reg;

    logic signed [63:0]      phi_reg  [3][3][2];
    logic signed [64:0]      plo_reg  [3][3][2];
    logic signed [63:0]      nw_reg   [3];
    logic signed [63:0]      nt_a_reg [3];
    logic signed [31:0]      n_a_reg  [3];
    logic signed [ACC_W-1:0] full_reg [3][3][2];
    logic signed [63:0]      kh_reg   [3];
    logic signed [64:0]      kl_reg   [3];
    logic signed [63:0]      nt_b_reg [3];
    logic signed [ACC_W-1:0] v_c_reg  [3][2];
    logic signed [ACC_W-1:0] k_reg    [3];
    logic signed [ACC_W-1:0] nts_reg;
    logic signed [ACC_W-1:0] v_d_reg  [3][2];
    logic signed [ACC_W-1:0] cst_reg;

    assign hit = (CELL_IDX < 8) && (item_i.slot == 3'(CELL_IDX));

    // Plane registers, written when a plane load for this slot passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                nrm_reg[a] <= 32'sd0;
            end
            dist_reg <= 32'sd0;
        end
        else if (en && ctl_i.vld && ctl_i.is_pload && hit)
        begin
            nrm_reg[0] <= $signed(item_i.words[0]);
            nrm_reg[1] <= $signed(item_i.words[1]);
            nrm_reg[2] <= $signed(item_i.words[2]);
            dist_reg   <= $signed(item_i.words[3]);
        end
    end

    // Stage control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_i;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
            ctl_d_reg <= ctl_c_reg;
            ctl_e_reg <= ctl_e_next;
        end
    end

    // Stage A: normal times each product half, normal times distance and translation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_a_reg <= item_i;
            for (int a = 0; a < 3; a++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        phi_reg[a][j][s] <= nrm_reg[a] * $signed(item_i.prod[a][j][s][63:32]);
                        plo_reg[a][j][s] <= nrm_reg[a] * $signed({1'b0, item_i.prod[a][j][s][31:0]});
                    end
                end
                nw_reg[a]   <= nrm_reg[a] * dist_reg;
                nt_a_reg[a] <= nrm_reg[a] * $signed(item_i.trans[a]);
                n_a_reg[a]  <= nrm_reg[a];
            end
        end
    end

    // Stage B: join product halves; normal times (normal times distance) in halves.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_b_reg <= item_a_reg;
            for (int a = 0; a < 3; a++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        full_reg[a][j][s] <= (ACC_W'(phi_reg[a][j][s]) <<< 32)
                                             + ACC_W'(plo_reg[a][j][s]);
                    end
                end
                kh_reg[a]   <= n_a_reg[a] * $signed(nw_reg[a][63:32]);
                kl_reg[a]   <= n_a_reg[a] * $signed({1'b0, nw_reg[a][31:0]});
                nt_b_reg[a] <= nt_a_reg[a];
            end
        end
    end

    // Stage C: sum over axes per coordinate choice; finish the distance terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_c_reg <= item_b_reg;
            for (int j = 0; j < 3; j++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    v_c_reg[j][s] <= full_reg[0][j][s] + full_reg[1][j][s] + full_reg[2][j][s];
                end
            end
            for (int a = 0; a < 3; a++)
            begin
                k_reg[a] <= (ACC_W'(kh_reg[a]) <<< 32) + ACC_W'(kl_reg[a]);
            end
            nts_reg <= ACC_W'(nt_b_reg[0]) + ACC_W'(nt_b_reg[1]) + ACC_W'(nt_b_reg[2]);
        end
    end

    // Stage D: constant part of the plane test, translation less distance terms.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_d_reg <= item_c_reg;
            v_d_reg    <= v_c_reg;
            cst_reg    <= (nts_reg <<< FRACTION_BITS) - k_reg[0] - k_reg[1] - k_reg[2];
        end
    end

    // Stage E: the eight corner sums; the box is culled here if every one is negative.
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        logic                    all_out;
        all_out = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            acc = v_d_reg[0][i[0]] + v_d_reg[1][i[1]]
                  + v_d_reg[2][i[2]] + cst_reg;
            all_out = all_out & acc[ACC_W-1];
        end
        ctl_e_next     = ctl_d_reg;
        ctl_e_next.vis = ctl_d_reg.vis & ~(ctl_d_reg.is_test & all_out);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_e_reg <= item_d_reg;
        end
    end

    assign ctl_o  = ctl_e_reg;
    assign item_o = item_e_reg;

endmodule

// ----- hdl/box_frustum_cull_test_unit.sv -----
// Top level of the box frustum cull test unit: front stage, chain of plane cells, output.
// Depends on bfc_pkg, bfc_xform, bfc_cell and box_frustum_cull_test_unit_assert.svh.

// One item is taken every cycle while input ready is high. A test result passes from its
// transfer in through the registers in order: the transfer itself loads the matrix front
// stage register, then each plane cell of the chain adds five pipeline stages and the
// output register one more. Loads produce no result; a plane load takes effect for every
// test transferred after it, as it reaches its cell ahead of them.
// Input ready falls only while a finished result waits in the output register and the
// next test result has reached the end of the chain.
`include "box_frustum_cull_test_unit_assert.svh"

module box_frustum_cull_test_unit
    import bfc_pkg::*;
#(
    parameter int PLANE_COUNT   = 6,
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         slot,
    input  logic signed [31:0] word_a,
    input  logic signed [31:0] word_b,
    input  logic signed [31:0] word_c,
    input  logic signed [31:0] word_d,
    input  logic signed [31:0] word_e,
    input  logic signed [31:0] word_f,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               visible
);

    ctl_t  chain_ctl  [PLANE_COUNT+1];
    item_t chain_item [PLANE_COUNT+1];
    logic  en;
    logic  fire;
    logic  tail_test;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  visible_reg;
    logic  visible_next;

    // The whole chain moves unless a result at its end has nowhere to go.
    assign tail_test = chain_ctl[PLANE_COUNT].vld && chain_ctl[PLANE_COUNT].is_test;
    assign en        = !(tail_test && out_valid_reg && !out_ready);
    assign in_ready  = en;
    assign fire      = in_valid && en;

    bfc_xform #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_xform (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .fire   (fire),
        .opcode (opcode),
        .slot   (slot),
        .word_a (word_a),
        .word_b (word_b),
        .word_c (word_c),
        .word_d (word_d),
        .word_e (word_e),
        .word_f (word_f),
        .ctl_o  (chain_ctl[0]),
        .item_o (chain_item[0])
    );

    // One cell per plane.
    for (genvar k = 0; k < PLANE_COUNT; k++)
    begin : g_cell
        bfc_cell #(
            .CELL_IDX     (k),
            .FRACTION_BITS(FRACTION_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_i  (chain_ctl[k]),
            .item_i (chain_item[k]),
            .ctl_o  (chain_ctl[k+1]),
            .item_o (chain_item[k+1])
        );
    end

    // Output register; a new result may replace one taken in the same cycle.
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        visible_next   = visible_reg;
        if (en && tail_test)
        begin
            out_valid_next = 1'b1;
            visible_next   = chain_ctl[PLANE_COUNT].vis;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;

    // The input stalls only behind a waiting result.
    `BFC_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && !out_ready)
    // A result appears only when a test leaves the chain.
    `BFC_ASSERT_SAME(a_rise_from_test, $rose(out_valid), $past(tail_test))
    // A taken result with no test behind it leaves the output empty.
    `BFC_ASSERT_NEXT(a_drain, out_valid && out_ready && !tail_test, !out_valid)
    // Matrix row loads never enter the plane chain.
    `BFC_ASSERT_NEXT(a_row_absorbed, in_valid && in_ready && opcode == OP_ROW, !chain_ctl[0].vld)

endmodule

// ----- tb/box_frustum_cull_checker.sv -----
// Checker for the box frustum cull test unit: watches both channels, predicts visibility.
// Depends on bfc_pkg for the opcodes; instantiated by box_frustum_cull_test_unit_tb.
module box_frustum_cull_checker
    import bfc_pkg::*;
#(
    parameter int PLANE_COUNT   = 6,
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [2:0]         slot,
    input  logic signed [31:0] word_a,
    input  logic signed [31:0] word_b,
    input  logic signed [31:0] word_c,
    input  logic signed [31:0] word_d,
    input  logic signed [31:0] word_e,
    input  logic signed [31:0] word_f,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               visible,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copies of the plane store and the transform rows.
    logic signed [31:0] plane_copy [PLANE_COUNT][4];
    logic signed [31:0] row_copy   [3][4];
    logic               visible_q  [$];

    // Exact box test: all arithmetic at 128 bits, which no intermediate can exceed.
    function automatic logic box_visible(input logic signed [31:0] bmin [3],
                                         input logic signed [31:0] bmax [3]);
        logic signed [127:0] crn [8][3];
        logic signed [127:0] px, py, pz, acc, nrm, plane_w;
        logic                outside_all;
        logic                vis;
        vis = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            px = (i & 1) ? bmax[0] : bmin[0];
            py = (i & 2) ? bmax[1] : bmin[1];
            pz = (i & 4) ? bmax[2] : bmin[2];
            for (int a = 0; a < 3; a++)
            begin
                acc = row_copy[a][3];
                crn[i][a] = 128'(signed'(row_copy[a][0])) * px
                          + 128'(signed'(row_copy[a][1])) * py
                          + 128'(signed'(row_copy[a][2])) * pz
                          + (acc <<< FRACTION_BITS);
            end
        end
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            outside_all = 1'b1;
            plane_w = plane_copy[p][3];
            for (int i = 0; i < 8; i++)
            begin
                acc = '0;
                for (int a = 0; a < 3; a++)
                begin
                    nrm = plane_copy[p][a];
                    acc = acc + (crn[i][a] - nrm * plane_w) * nrm;
                end
                if (acc >= 0)
                    outside_all = 1'b0;
            end
            if (outside_all)
                vis = 1'b0;
        end
        return vis;
    endfunction

    // Predict on each input transfer and compare on each output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [31:0] bmin [3];
        logic signed [31:0] bmax [3];
        logic               exp_vis;
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
                for (int k = 0; k < 4; k++)
                    plane_copy[p][k] <= '0;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 4; k++)
                    row_copy[r][k] <= (r == k) ? (32'sd1 <<< FRACTION_BITS) : 32'sd0;
            visible_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (visible_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, visible=%0b",
                             $time, visible);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_vis = visible_q.pop_front();
                    if (exp_vis !== visible)
                    begin
                        $display("%0t: visible mismatch, expected %0b, actual %0b",
                                 $time, exp_vis, visible);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                case (opcode)
                    OP_PLANE:
                    begin
                        if (slot < PLANE_COUNT)
                        begin
                            plane_copy[slot][0] <= word_a;
                            plane_copy[slot][1] <= word_b;
                            plane_copy[slot][2] <= word_c;
                            plane_copy[slot][3] <= word_d;
                        end
                    end
                    OP_ROW:
                    begin
                        if (slot < 3)
                        begin
                            row_copy[slot[1:0]][0] <= word_a;
                            row_copy[slot[1:0]][1] <= word_b;
                            row_copy[slot[1:0]][2] <= word_c;
                            row_copy[slot[1:0]][3] <= word_d;
                        end
                    end
                    OP_TEST:
                    begin
                        bmin[0] = word_a;
                        bmin[1] = word_b;
                        bmin[2] = word_c;
                        bmax[0] = word_d;
                        bmax[1] = word_e;
                        bmax[2] = word_f;
                        visible_q.push_back(box_visible(bmin, bmax));
                    end
                    default:
                    begin
                    end
                endcase
            end
            pending <= visible_q.size();
        end
    end

endmodule

// ----- tb/box_frustum_cull_test_unit_tb.sv -----
// Testbench top for the box frustum cull test unit: clock, reset, stimulus and verdict.
// Depends on bfc_pkg, the block itself and box_frustum_cull_checker.
module box_frustum_cull_test_unit_tb;
    import bfc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int ONE = 65536;
    localparam int LATENCY = 5 * 6 + 1;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = '0;
    logic [2:0]         slot = '0;
    logic signed [31:0] word_a = '0, word_b = '0, word_c = '0;
    logic signed [31:0] word_d = '0, word_e = '0, word_f = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               visible;
    int                 errors;
    int                 pending;
    int                 cycle_no = 0;

    box_frustum_cull_test_unit dut (.*);
    box_frustum_cull_checker chk (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
        cycle_no <= cycle_no + 1;

    // Both sides run without gaps in this window.
    function automatic logic steady();
        return cycle_no >= 700 && cycle_no < 900;
    endfunction

    // Receiver: random idling, one long hold-off while the sender keeps offering.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (cycle_no == 400)
                hold_left = 250;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (steady())
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 33);
        end
    end

    // Signed fixed-point value in the range -span..span.
    function automatic logic signed [31:0] fx(input int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // Offer one item and wait for its transfer.
    task automatic offer(input logic [1:0] op, input logic [2:0] sl,
                         input logic signed [31:0] a, b, c, d, e, f);
        if (!steady() && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        slot     <= sl;
        word_a   <= a;
        word_b   <= b;
        word_c   <= c;
        word_d   <= d;
        word_e   <= e;
        word_f   <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // One random item: mostly well-formed scene loads and box tests, some noise.
    task automatic random_item();
        int pick;
        int ax;
        logic signed [31:0] n [3];
        logic signed [31:0] lo [3];
        pick = $urandom_range(99);
        if (pick < 12)
        begin
            ax = $urandom_range(2);
            for (int k = 0; k < 3; k++)
                n[k] = (k == ax) ? (($urandom_range(1)) ? ONE : -ONE) : fx(ONE / 4);
            offer(OP_PLANE, ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(5)),
                  n[0], n[1], n[2], fx(8 * ONE), $urandom, $urandom);
        end
        else if (pick < 18)
        begin
            ax = $urandom_range(3);
            offer(OP_ROW, 3'(ax), (ax == 0) ? ONE : fx(ONE / 2),
                  (ax == 1) ? ONE : fx(ONE / 2), (ax == 2) ? ONE : fx(ONE / 2),
                  fx(4 * ONE), $urandom, $urandom);
        end
        else if (pick < 26)
        begin
            // Noise: full-range words, stray opcodes and out-of-range slots.
            offer(2'($urandom_range(3)), 3'($urandom_range(7)), $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
        end
        else
        begin
            for (int k = 0; k < 3; k++)
                lo[k] = fx(16 * ONE);
            offer(OP_TEST, 3'($urandom_range(7)), lo[0], lo[1], lo[2],
                  lo[0] + fx(2 * ONE), lo[1] + fx(2 * ONE), lo[2] + fx(2 * ONE));
        end
    endtask

    // Limit on the whole run.
    initial
    begin
        #2_000_000;
        $display("box_frustum_cull_test_unit regression: fail");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int waited;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, extremes, stray codes, inverted and touching boxes.
        offer(OP_TEST, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        offer(OP_PLANE, 3'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'hffff_ffff, 32'h0);
        offer(OP_TEST, 3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'h0,
              32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        offer(OP_PLANE, 3'd0, ONE, 0, 0, 0, 0, 0);
        offer(OP_TEST, 3'd0, -2 * ONE, 0, 0, -ONE, ONE, ONE);
        offer(OP_TEST, 3'd0, -2 * ONE, 0, 0, 0, ONE, ONE);
        offer(OP_TEST, 3'd0, ONE, 0, 0, -3 * ONE, ONE, ONE);
        offer(OP_PLANE, 3'd6, -ONE, 0, 0, 0, 0, 0);
        offer(OP_PLANE, 3'd7, -ONE, 0, 0, 0, 0, 0);
        offer(OP_TEST, 3'd0, -2 * ONE, 0, 0, -ONE, ONE, ONE);
        offer(OP_NONE, 3'd0, -ONE, 0, 0, 0, 0, 0);
        offer(OP_PLANE, 3'd5, 0, -ONE, 0, ONE, 0, 0);
        offer(OP_TEST, 3'd0, 0, 2 * ONE, 0, ONE, 3 * ONE, ONE);
        offer(OP_ROW, 3'd1, 0, ONE, 0, -4 * ONE, 0, 0);
        offer(OP_TEST, 3'd0, 0, 2 * ONE, 0, ONE, 3 * ONE, ONE);
        offer(OP_ROW, 3'd3, 0, 0, 0, 32'h7fff_ffff, 0, 0);
        offer(OP_ROW, 3'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 0, 0);
        offer(OP_TEST, 3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        offer(OP_ROW, 3'd0, ONE, 0, 0, 0, 0, 0);
        offer(OP_PLANE, 3'd0, 0, 0, 0, 0, 0, 0);
        offer(OP_PLANE, 3'd5, 0, 0, 0, 0, 0, 0);

        // Random part.
        for (int i = 0; i < 450; i++)
            random_item();
        in_valid <= 1'b0;

        // Drain, then wait out the pipeline.
        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * LATENCY) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("box_frustum_cull_test_unit regression: pass");
        else
            $display("box_frustum_cull_test_unit regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/bfc_pkg.sv
hdl/bfc_xform.sv
hdl/bfc_cell.sv
hdl/box_frustum_cull_test_unit.sv
tb/box_frustum_cull_checker.sv
tb/box_frustum_cull_test_unit_tb.sv
